// ===== hw/rtl/bsfd_pkg.sv =====
// ----------------------------------------------------------------------------
// bsfd_pkg
// Shared types, codes and the seven-segment table for the four digit setter
// and display scanner.
// ----------------------------------------------------------------------------
package bsfd_pkg;

   // Number of display digits and widths derived from it.
   localparam int NUM_DIGITS  = 4;
   localparam int DIGIT_W     = 4;
   localparam int SEL_W       = 2;
   localparam int SEG_W       = 7;
   localparam int CNT_W       = 8;
   localparam int CSR_IDX_W   = 2;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   // Item kinds carried on the request tuser bit.
   localparam logic OP_BUTTON = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_REPEAT_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SELECT_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_REFRESH_PERIOD   = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [CNT_W-1:0] RESET_REPEAT_THRESHOLD = 8'd20;
   localparam logic [CNT_W-1:0] RESET_SELECT_THRESHOLD = 8'd50;
   localparam logic [CNT_W-1:0] RESET_REFRESH_PERIOD   = 8'd20;

   localparam logic [CNT_W-1:0]   COUNT_MAX = 8'd255;
   localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

   // The four digit values of one scan, units in entry 0.
   typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_type;

   // A scan request handed from the front end to the queue.
   typedef struct packed {
      logic       valid;
      digits_type digits;
   } scan_push_type;

   // Common cathode patterns, bit 0 = segment a; codes above nine are blank.
   function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] value);
      logic [SEG_W-1:0] pattern;
      unique case (value)
         4'd0:    pattern = 7'h3F;
         4'd1:    pattern = 7'h06;
         4'd2:    pattern = 7'h5B;
         4'd3:    pattern = 7'h4F;
         4'd4:    pattern = 7'h66;
         4'd5:    pattern = 7'h6D;
         4'd6:    pattern = 7'h7D;
         4'd7:    pattern = 7'h07;
         4'd8:    pattern = 7'h7F;
         4'd9:    pattern = 7'h6F;
         default: pattern = 7'h00;
      endcase
      return pattern;
   endfunction

endpackage

// ===== hw/rtl/bsfd_front.sv =====
// ----------------------------------------------------------------------------
// bsfd_front
// Accepts button samples and ticks, keeps the hold and refresh counters, the
// digit values and the configuration registers, and requests display scans.
// ----------------------------------------------------------------------------
module bsfd_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [7:0]                   req_tdata,   // up, down, select, zero fill
   input  logic                         req_tuser,   // kind: 0 button, 1 tick
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [bsfd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bsfd_pkg::CNT_W-1:0]   csr_data,
   input  logic                         queue_full,
   output bsfd_pkg::scan_push_type      push
);
   import bsfd_pkg::*;

   logic [CNT_W-1:0] repeat_thr_ff, repeat_thr_in;
   logic [CNT_W-1:0] select_thr_ff, select_thr_in;
   logic [CNT_W-1:0] period_ff, period_in;
   logic [CNT_W-1:0] hold_ff, hold_in;
   logic [CNT_W-1:0] refresh_ff, refresh_in;
   logic [SEL_W-1:0] sel_ff, sel_in;
   digits_type       digits_ff, digits_in;

   logic             accept;
   logic             up, down, sel_btn;
   logic [CNT_W-1:0] hold_bump;
   logic [CNT_W-1:0] refresh_bump;
   logic [DIGIT_W-1:0] cur_digit;
   logic [DIGIT_W-1:0] down_step;

   // A tick may need a queue slot, so items are taken only while one is free.
   assign req_tready = !queue_full;
   assign csr_ready  = 1'b1;
   assign accept     = req_tvalid && req_tready;

   assign up      = req_tdata[0];
   assign down    = req_tdata[1];
   assign sel_btn = req_tdata[2];

   assign hold_bump    = (hold_ff == COUNT_MAX) ? hold_ff : hold_ff + 8'd1;
   assign refresh_bump = (refresh_ff == COUNT_MAX) ? refresh_ff : refresh_ff + 8'd1;
   assign cur_digit    = digits_ff[sel_ff];
   assign down_step    = (cur_digit == 4'd0) ? 4'd0 : cur_digit - 4'd1;

   // Configuration writes; indexes outside the list are dropped.
   always_comb begin
      repeat_thr_in = repeat_thr_ff;
      select_thr_in = select_thr_ff;
      period_in     = period_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_REPEAT_THRESHOLD: repeat_thr_in = csr_data;
            REG_SELECT_THRESHOLD: select_thr_in = csr_data;
            REG_REFRESH_PERIOD:   period_in     = csr_data;
            default: ;
         endcase
      end
   end

   // Item classification and the state updates that follow from it.
   always_comb begin
      hold_in     = hold_ff;
      refresh_in  = refresh_ff;
      sel_in      = sel_ff;
      digits_in   = digits_ff;
      push.valid  = 1'b0;
      push.digits = digits_ff;
      if (accept) begin
         if (req_tuser == OP_TICK) begin
            if (refresh_bump >= period_ff) begin
               push.valid = 1'b1;
               refresh_in = '0;
            end else begin
               refresh_in = refresh_bump;
            end
         end else begin
            priority if (up || down) begin
               if (hold_ff > repeat_thr_ff) begin
                  hold_in = '0;
                  if (up) begin
                     digits_in[sel_ff] = (cur_digit >= DIGIT_MAX) ? 4'd0 : cur_digit + 4'd1;
                  end else begin
                     digits_in[sel_ff] = (down_step > DIGIT_MAX) ? 4'd0 : down_step;
                  end
               end else begin
                  hold_in = hold_bump;
               end
            end else if (sel_btn) begin
               if (hold_ff > select_thr_ff) begin
                  hold_in = '0;
                  sel_in  = sel_ff + 2'd1;
               end else begin
                  hold_in = hold_bump;
               end
            end else begin
               hold_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         repeat_thr_ff <= RESET_REPEAT_THRESHOLD;
         select_thr_ff <= RESET_SELECT_THRESHOLD;
         period_ff     <= RESET_REFRESH_PERIOD;
         hold_ff       <= '0;
         refresh_ff    <= '0;
         sel_ff        <= '0;
         digits_ff     <= '0;
      end else begin
         repeat_thr_ff <= repeat_thr_in;
         select_thr_ff <= select_thr_in;
         period_ff     <= period_in;
         hold_ff       <= hold_in;
         refresh_ff    <= refresh_in;
         sel_ff        <= sel_in;
         digits_ff     <= digits_in;
      end
   end

   // The front end must never push into a full queue.
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      queue_full |-> !push.valid)
      else $error("scan pushed while queue full");

   // Digits only ever hold decimal values.
   a_digits_decimal: assert property (@(posedge clock) disable iff (reset)
      (digits_ff[0] <= DIGIT_MAX) && (digits_ff[1] <= DIGIT_MAX) &&
      (digits_ff[2] <= DIGIT_MAX) && (digits_ff[3] <= DIGIT_MAX))
      else $error("digit value above nine");

   // A scan clears the refresh counter.
   a_scan_clears_refresh: assert property (@(posedge clock) disable iff (reset)
      push.valid |=> (refresh_ff == '0))
      else $error("refresh counter not cleared after scan");

endmodule

// ===== hw/rtl/bsfd_queue.sv =====
// ----------------------------------------------------------------------------
// bsfd_queue
// Two-entry queue of scan requests between the front end and the scanner.
// ----------------------------------------------------------------------------
module bsfd_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  bsfd_pkg::scan_push_type push,
   output logic                    full,
   output logic                    not_empty,
   input  logic                    pop,
   output bsfd_pkg::digits_type    head
);
   import bsfd_pkg::*;

   digits_type        entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push.valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push.valid) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.digits;
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count overflow");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty queue");

   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      (push.valid && !pop) |=> not_empty)
      else $error("pushed entry lost");

endmodule

// ===== hw/rtl/bsfd_back.sv =====
// ----------------------------------------------------------------------------
// bsfd_back
// Display scanner: takes one scan request at a time and emits its four
// segment words, units first, through a registered output stage.
// ----------------------------------------------------------------------------
module bsfd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 not_empty,
   input  bsfd_pkg::digits_type head,
   output logic                 pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,   // segments[6:0], digit_enable[10:7], zero fill
   output logic                 rsp_tlast    // last word of a scan
);
   import bsfd_pkg::*;

   digits_type             cur_ff, cur_in;
   logic                   cur_valid_ff, cur_valid_in;
   logic [SEL_W-1:0]       idx_ff, idx_in;
   logic                   out_valid_ff, out_valid_in;
   logic [SEG_W-1:0]       seg_ff, seg_in;
   logic [NUM_DIGITS-1:0]  en_ff, en_in;
   logic                   last_ff, last_in;
   logic                   load;
   logic                   finishing;

   // A word moves to the output stage whenever that stage is free or drains.
   assign load      = cur_valid_ff && (!out_valid_ff || rsp_tready);
   assign finishing = load && (idx_ff == SEL_W'(NUM_DIGITS - 1));
   assign pop       = not_empty && (!cur_valid_ff || finishing);

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      seg_in       = seg_ff;
      en_in        = en_ff;
      last_in      = last_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (load) begin
         out_valid_in = 1'b1;
         seg_in       = seg_pattern(cur_ff[idx_ff]);
         en_in        = NUM_DIGITS'(1) << idx_ff;
         last_in      = finishing;
         idx_in       = idx_ff + 2'd1;
         if (finishing) begin
            cur_valid_in = 1'b0;
         end
      end
      if (pop) begin
         cur_in       = head;
         cur_valid_in = 1'b1;
         idx_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      seg_ff  <= seg_in;
      en_ff   <= en_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, en_ff, seg_ff};
   assign rsp_tlast  = last_ff;

   a_enable_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot(en_ff))
      else $error("digit enable not one-hot");

   a_last_on_thousands: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (last_ff == en_ff[NUM_DIGITS-1]))
      else $error("last flag not on the fourth word");

   a_scan_unbroken: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> rsp_tvalid)
      else $error("gap inside a scan");

endmodule

// ===== hw/rtl/button_set_four_digit_display.sv =====
// ----------------------------------------------------------------------------
// button_set_four_digit_display
// Four digit decimal setter driven by up, down and select buttons, with a
// multiplexed seven-segment scan emitted on every refresh period.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries button samples (tuser 0, tdata bits up, down, select) and
//   millisecond ticks (tuser 1). One item is taken per cycle while a slot is
//   free in the two-entry scan queue; button samples give no result.
//   rsp_* carries segment words: tdata holds the pattern and a one-hot digit
//   enable, tlast marks the thousands word that ends a scan.
//   csr_* writes the repeat threshold, select threshold and refresh period;
//   it is always ready and should be used while the block is idle.
// Flow: a tick that completes a period passes through the scan queue and the
//   scanner's current-scan register before its first word reaches the output
//   register; a scan then gives one word per cycle while the receiver is ready,
//   so the scanner sets the sustained rate of scan-producing ticks.
// Reset (synchronous) restores the register defaults, clears counters, the
//   selection and the digits, and empties the queue and output stage.
// When the receiver stalls, words wait in the output register, the queue
//   fills and req_tready falls once both entries are taken.
// ----------------------------------------------------------------------------
module button_set_four_digit_display (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // up_pressed, down_pressed, select_pressed, zero fill
   input  logic        req_tuser,   // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // segments[6:0], digit_enable[10:7], zero fill
   output logic        rsp_tlast,   // last_of_scan
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [bsfd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bsfd_pkg::CNT_W-1:0]     csr_data
);
   import bsfd_pkg::*;

   scan_push_type push;
   logic          queue_full;
   logic          queue_not_empty;
   logic          queue_pop;
   digits_type    queue_head;

   bsfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .queue_full (queue_full),
      .push       (push)
   );

   bsfd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .pop       (queue_pop),
      .head      (queue_head)
   );

   bsfd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .not_empty  (queue_not_empty),
      .head       (queue_head),
      .pop        (queue_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== tb/button_set_four_digit_display_check.sv =====
// ----------------------------------------------------------------------------
// button_set_four_digit_display_check
// Watches the request, response and register channels of the digit setter,
// keeps its own copy of the hold counter, selection, digits and refresh
// counter, and compares every display word with the scan it predicted.
// ----------------------------------------------------------------------------
module button_set_four_digit_display_check (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // up_pressed, down_pressed, select_pressed, zero fill
   input  logic                           req_tuser,   // opcode
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [15:0]                    rsp_tdata,   // segments[6:0], digit_enable[10:7], zero fill
   input  logic                           rsp_tlast,   // last_of_scan
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [bsfd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bsfd_pkg::CNT_W-1:0]     csr_data,
   output int                             failures,
   output int                             pending,
   output int                             words_seen,
   output int                             digit_steps
);
   import bsfd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // Bit positions of the buttons within an item's data.
   localparam int UP_BIT     = 0;
   localparam int DOWN_BIT   = 1;
   localparam int SELECT_BIT = 2;

   // Segment patterns indexed by digit value; codes above nine are blank.
   localparam logic [15:0][SEG_W-1:0] GLYPHS = {
      {6{7'h00}}, 7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D,
      7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
   };

   typedef struct packed {
      logic [SEG_W-1:0]      segments;
      logic [NUM_DIGITS-1:0] enable;
      logic                  last;
   } display_word_type;

   // Register copies and the predicted state of the block.
   logic [CNT_W-1:0]   repeat_limit;
   logic [CNT_W-1:0]   select_limit;
   logic [CNT_W-1:0]   scan_period;
   logic [CNT_W-1:0]   hold_count;
   logic [CNT_W-1:0]   refresh_count;
   logic [SEL_W-1:0]   cursor;
   logic [DIGIT_W-1:0] digit_value [NUM_DIGITS];

   display_word_type scan_words [$];
   int               reported;

   // Works out the effect of one accepted item and queues any scan it causes.
   task automatic predict_item(input logic is_tick, input logic [2:0] buttons);
      display_word_type w;
      logic             up;
      logic             down;
      logic             sel;
      up   = buttons[UP_BIT];
      down = buttons[DOWN_BIT];
      sel  = buttons[SELECT_BIT];
      if (!is_tick) begin
         if (up || down) begin
            if (hold_count > repeat_limit) begin
               if (up) begin
                  digit_value[cursor] = (digit_value[cursor] >= DIGIT_MAX) ?
                                        '0 : digit_value[cursor] + 1'b1;
               end else if (digit_value[cursor] != '0) begin
                  digit_value[cursor] = digit_value[cursor] - 1'b1;
               end
               hold_count = '0;
               digit_steps++;
            end else if (hold_count < COUNT_MAX) begin
               hold_count = hold_count + 1'b1;
            end
         end else if (sel) begin
            if (hold_count > select_limit) begin
               cursor     = cursor + 1'b1;
               hold_count = '0;
               digit_steps++;
            end else if (hold_count < COUNT_MAX) begin
               hold_count = hold_count + 1'b1;
            end
         end else begin
            hold_count = '0;
         end
      end else begin
         if (refresh_count < COUNT_MAX) refresh_count = refresh_count + 1'b1;
         if (refresh_count >= scan_period) begin
            refresh_count = '0;
            for (int k = 0; k < NUM_DIGITS; k++) begin
               w.segments  = GLYPHS[digit_value[k]];
               w.enable    = '0;
               w.enable[k] = 1'b1;
               w.last      = (k == NUM_DIGITS - 1);
               scan_words.push_back(w);
            end
         end
      end
   endtask

   // All three channels are sampled on the rising edge, before the block's
   // own registers move.
   always @(posedge clock) begin
      display_word_type got;
      display_word_type want;
      if (reset) begin
         repeat_limit  = RESET_REPEAT_THRESHOLD;
         select_limit  = RESET_SELECT_THRESHOLD;
         scan_period   = RESET_REFRESH_PERIOD;
         hold_count    = '0;
         refresh_count = '0;
         cursor        = '0;
         for (int k = 0; k < NUM_DIGITS; k++) digit_value[k] = '0;
         scan_words.delete();
         failures    = 0;
         reported    = 0;
         words_seen  = 0;
         digit_steps = 0;
      end else begin
         // Register writes.
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_REPEAT_THRESHOLD: repeat_limit = csr_data;
               REG_SELECT_THRESHOLD: select_limit = csr_data;
               REG_REFRESH_PERIOD:   scan_period  = csr_data;
               default: ;
            endcase
         end

         // Display words against the oldest predicted word.
         if (rsp_tvalid && rsp_tready) begin
            got.segments = rsp_tdata[SEG_W-1:0];
            got.enable   = rsp_tdata[SEG_W +: NUM_DIGITS];
            got.last     = rsp_tlast;
            words_seen++;
            if (scan_words.size() == 0) begin
               failures++;
               if (reported < 10) begin
                  reported++;
                  $display("%t: display word seg %h enable %b last %b with no scan due",
                           $realtime, got.segments, got.enable, got.last);
               end
            end else begin
               want = scan_words.pop_front();
               if (got.segments != want.segments || got.enable != want.enable ||
                   got.last != want.last) begin
                  failures++;
                  if (reported < 10) begin
                     reported++;
                     $display("%t: display word wrong: expected seg %h enable %b last %b,",
                              $realtime, want.segments, want.enable, want.last);
                     $display("   got seg %h enable %b last %b",
                              got.segments, got.enable, got.last);
                  end
               end
            end
         end

         // Accepted items update the predicted state.
         if (req_tvalid && req_tready) predict_item(req_tuser == OP_TICK, req_tdata[2:0]);
      end
      pending = scan_words.size();
   end

endmodule

// ===== tb/button_set_four_digit_display_test.sv =====
// ----------------------------------------------------------------------------
// button_set_four_digit_display_test
// Drives button samples and millisecond ticks into the digit setter under a
// series of register settings, with random gaps and stalls on both streams,
// and leaves prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module button_set_four_digit_display_test;
   import bsfd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // Button masks as they sit in the low bits of an item's data.
   localparam logic [2:0] BTN_NONE   = 3'b000;
   localparam logic [2:0] BTN_UP     = 3'b001;
   localparam logic [2:0] BTN_DOWN   = 3'b010;
   localparam logic [2:0] BTN_SELECT = 3'b100;

   localparam int HOLD_OFF_CYCLES = 200;
   localparam int DRAIN_CYCLES    = 8;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [7:0]           req_tdata;
   logic                 req_tuser;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [15:0]          rsp_tdata;
   logic                 rsp_tlast;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CNT_W-1:0]     csr_data;

   int failures;
   int pending;
   int words_seen;
   int digit_steps;

   int               ticks_sent;
   int               samples_sent;
   bit               send_steady;
   bit               rsp_steady;
   int               hold_offs_asked;
   int               hold_offs_done;
   logic [CNT_W-1:0] repeat_now;
   logic [CNT_W-1:0] select_now;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   button_set_four_digit_display dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   button_set_four_digit_display_check checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .failures    (failures),
      .pending     (pending),
      .words_seen  (words_seen),
      .digit_steps (digit_steps)
   );

   // Offers one item after a random gap and waits until it is taken.
   task automatic offer(input logic op, input logic [2:0] buttons);
      int gap;
      gap = send_steady ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser  = op;
      req_tdata  = {5'b00000, buttons};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      req_tvalid = 1'b0;
      if (op == OP_TICK) ticks_sent++;
      else samples_sent++;
   endtask

   task automatic press(input logic [2:0] buttons, input int count);
      repeat (count) offer(OP_BUTTON, buttons);
   endtask

   // Waits for every predicted word, then for any button item still in flight.
   task automatic settle();
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [CNT_W-1:0] value);
      csr_index = index;
      csr_data  = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_thresholds(input logic [CNT_W-1:0] rep, input logic [CNT_W-1:0] sel,
                                 input logic [CNT_W-1:0] period);
      settle();
      write_reg(REG_REPEAT_THRESHOLD, rep);
      write_reg(REG_SELECT_THRESHOLD, sel);
      write_reg(REG_REFRESH_PERIOD, period);
      repeat_now = rep;
      select_now = sel;
   endtask

   // Mostly button holds of random length, some long enough to act, with ticks
   // mixed in, plus some single items with random content. Exactly count items are sent.
   task automatic button_traffic(input int count, input int tick_pct);
      int         made;
      int         len;
      int         roll;
      int         limit;
      logic [2:0] combo;
      made = 0;
      while (made < count) begin
         roll = $urandom_range(0, 99);
         if (roll < 15) begin
            offer((roll < 7) ? OP_TICK : OP_BUTTON, 3'($urandom));
            made++;
         end else begin
            combo = 3'($urandom_range(1, 7));
            limit = ((combo & (BTN_UP | BTN_DOWN)) != BTN_NONE) ? repeat_now : select_now;
            len   = $urandom_range(1, limit + 3);
            if (len > count - made) len = count - made;
            repeat (len) begin
               if ($urandom_range(0, 99) < tick_pct) offer(OP_TICK, 3'($urandom));
               else offer(OP_BUTTON, combo);
               made++;
            end
         end
      end
   endtask

   // Receiver: random stalls per word, and a long hold-off when asked.
   initial begin
      int gap;
      rsp_tready = 1'b0;
      forever begin
         if (hold_offs_done < hold_offs_asked) begin
            rsp_tready = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_offs_done++;
         end
         gap = rsp_steady ? 0 : $urandom_range(0, 9);
         if (gap != 0) begin
            rsp_tready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // Stimulus and verdict.
   initial begin
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      req_tuser       = OP_BUTTON;
      csr_valid       = 1'b0;
      csr_index       = REG_REPEAT_THRESHOLD;
      csr_data        = '0;
      send_steady     = 1'b0;
      rsp_steady      = 1'b0;
      hold_offs_asked = 0;
      hold_offs_done  = 0;
      ticks_sent      = 0;
      samples_sent    = 0;
      repeat_now      = RESET_REPEAT_THRESHOLD;
      select_now      = RESET_SELECT_THRESHOLD;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // Directed: every action after two samples, a scan on every tick.
      set_thresholds(8'd0, 8'd0, 8'd1);
      offer(OP_TICK, BTN_NONE);
      press(BTN_UP, 2);
      press(BTN_UP | BTN_DOWN | BTN_SELECT, 2);   // up wins over the others
      press(BTN_DOWN | BTN_SELECT, 2);            // down wins over select
      press(BTN_DOWN, 4);                         // down stops at zero
      press(BTN_NONE, 1);                         // release clears the hold
      press(BTN_SELECT, 2);
      press(BTN_UP, 2);
      offer(OP_TICK, BTN_UP | BTN_DOWN | BTN_SELECT);   // buttons ignored on a tick
      press(BTN_SELECT, 4);
      press(BTN_UP, 2);
      press(BTN_SELECT, 2);                       // selection wraps back to units
      offer(OP_TICK, BTN_UP | BTN_SELECT);

      // Small thresholds, with one pause until the display has caught up.
      set_thresholds(8'd2, 8'd4, 8'd3);
      button_traffic(20, 25);
      while (pending != 0) @(negedge clock);
      button_traffic(20, 25);

      // Zero period: every tick scans, while the receiver holds off.
      set_thresholds(8'd0, 8'd1, 8'd0);
      send_steady = 1'b1;
      hold_offs_asked++;
      button_traffic(30, 40);

      // Highest settings: long holds that stay below the thresholds.
      send_steady = 1'b0;
      set_thresholds(8'd254, 8'd254, 8'd255);
      press(BTN_UP, 40);
      repeat (6) offer(OP_TICK, 3'($urandom));
      button_traffic(10, 10);

      // Period lowered below the count, no idling on either side.
      set_thresholds(8'd1, 8'd2, 8'd2);
      send_steady = 1'b1;
      rsp_steady  = 1'b1;
      button_traffic(30, 30);

      // Random small settings, then the reset values.
      send_steady = 1'b0;
      rsp_steady  = 1'b0;
      set_thresholds(8'($urandom_range(0, 15)), 8'($urandom_range(0, 15)),
                     8'($urandom_range(1, 6)));
      button_traffic(25, 25);
      set_thresholds(RESET_REPEAT_THRESHOLD, RESET_SELECT_THRESHOLD, RESET_REFRESH_PERIOD);
      button_traffic(25, 20);

      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Sent %0d button samples and %0d ticks across seven register settings.",
               samples_sent, ticks_sent);
      $display("Compared %0d display words; %0d digit or selection steps were predicted.",
               words_seen, digit_steps);
      if (failures == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog far beyond the slowest legal run.
   initial begin
      #5ms;
      $display("Run stopped by the watchdog with %0d display words outstanding.", pending);
      $display("end of test: mismatches");
      $finish;
   end

endmodule
